/* src/wtaf_pkg.sv */
// ----------------------------------------------------------------------------
// wtaf_pkg
// Shared widths, register codes and reset values of the windowed trend
// alert filter.
// ----------------------------------------------------------------------------
package wtaf_pkg;

  // Field widths of the detection and result channels.
  localparam int AREA_IN_W  = 20;
  localparam int CENT_W     = 16;
  localparam int PROD_W     = AREA_IN_W + CENT_W;
  localparam int WSUM_W     = 40;
  localparam int CNT_W      = 6;
  localparam int RATIO_W    = 16;

  // Configuration channel widths.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WINDOW_LEN = 2'd0,
    CFG_MIN_HIT    = 2'd1,
    CFG_GROWTH     = 2'd2,
    CFG_DOWN       = 2'd3
  } cfg_idx_t;

  // Register values after reset.
  localparam logic [CNT_W-1:0]   WINDOW_LEN_RST = 6'd8;
  localparam logic [CNT_W-1:0]   MIN_HIT_RST    = 6'd5;
  localparam logic [RATIO_W-1:0] GROWTH_RST     = 16'd307;
  localparam logic [CENT_W-1:0]  DOWN_RST       = 16'd80;

endpackage

/* src/wtaf_if.sv */
// ----------------------------------------------------------------------------
// wtaf_if
// Valid/ready channels of the filter: detections in, frame results out,
// and register writes.
// ----------------------------------------------------------------------------

// One detection, or an empty frame marker, per transfer.
interface wtaf_in_if;
  logic                           valid;
  logic                           ready;
  logic                           has_detection;
  logic [wtaf_pkg::AREA_IN_W-1:0] det_area;
  logic [wtaf_pkg::CENT_W-1:0]    det_centroid_y;
  logic                           frame_last;

  modport source (output valid, has_detection, det_area, det_centroid_y, frame_last,
                  input ready);
  modport sink   (input valid, has_detection, det_area, det_centroid_y, frame_last,
                  output ready);
endinterface

// One trend result per frame.
interface wtaf_out_if;
  logic                       valid;
  logic                       ready;
  logic                       alert;
  logic [wtaf_pkg::CNT_W-1:0] hit_tally;
  logic                       area_rising;
  logic                       centroid_falling;

  modport source (output valid, alert, hit_tally, area_rising, centroid_falling,
                  input ready);
  modport sink   (input valid, alert, hit_tally, area_rising, centroid_falling,
                  output ready);
endinterface

// Register write channel.
interface wtaf_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [wtaf_pkg::CFG_IDX_W-1:0]  index;
  logic [wtaf_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/wtaf_div.sv */
// ----------------------------------------------------------------------------
// wtaf_div
// Iterative divider for the frame mean centroid: weighted sum over total
// area, truncated, clamped to the centroid range, zero for a zero area.
// ----------------------------------------------------------------------------
module wtaf_div #(
  parameter int AREA_SUM_BITS = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [wtaf_pkg::WSUM_W-1:0]   dividend,
  input  logic [AREA_SUM_BITS-1:0]      divisor,
  output logic                          done,
  output logic [wtaf_pkg::CENT_W-1:0]   quotient
);

  localparam int CW = (wtaf_pkg::WSUM_W > AREA_SUM_BITS + wtaf_pkg::CENT_W) ?
                      wtaf_pkg::WSUM_W : AREA_SUM_BITS + wtaf_pkg::CENT_W;
  localparam int RW = AREA_SUM_BITS + 1;
  localparam int QW = wtaf_pkg::CENT_W;

  logic                 busy;
  logic [$clog2(QW)-1:0] step;
  logic [RW-1:0]        rem;
  logic [QW-1:0]        low_bits;
  logic                 overflow;
  logic [RW-1:0]        trial;
  logic                 fits;

  // The quotient needs more than the centroid width exactly when the
  // dividend reaches the divisor shifted up by that width.
  assign overflow = CW'(dividend) >= (CW'(divisor) << QW);

  // One restoring step: bring in the next dividend bit and try a subtract.
  assign trial = {rem[RW-2:0], low_bits[QW-1]};
  assign fits  = trial >= RW'(divisor);

  // Control: idle until start, then one quotient bit per cycle, or straight to done for a zero divisor or an overflow.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        step <= '0;
        if (divisor == '0 || overflow) begin
          done <= 1'b1;
        end else begin
          busy <= 1'b1;
        end
      end else if (busy) begin
        step <= step + 1'b1;
        if (step == ($clog2(QW))'(QW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: while dividing, the partial remainder stays below the divisor.
  always_ff @(posedge clk) begin
    if (start) begin
      if (divisor == '0) begin
        quotient <= '0;
      end else if (overflow) begin
        quotient <= '1;
      end else begin
        quotient <= '0;
      end
      rem      <= RW'(dividend >> QW);
      low_bits <= dividend[QW-1:0];
    end else if (busy) begin
      rem      <= fits ? trial - RW'(divisor) : trial;
      quotient <= {quotient[QW-2:0], fits};
      low_bits <= {low_bits[QW-2:0], 1'b0};
    end
  end

endmodule

/* src/windowed_trend_alert_filter.sv */
// ----------------------------------------------------------------------------
// windowed_trend_alert_filter
// Per-frame area and centroid trend detector over a sliding history window.
// ----------------------------------------------------------------------------
// A detection transfer is accepted in S_IDLE and accumulated in S_ACC. At the
// end of a frame the block runs the bit-serial centroid divider, writes the
// frame into the history memory, then sweeps one history entry per cycle over
// the filled window to count hits and fetch the oldest frame, and compares in
// S_CMP before the result is loaded in S_FIN. The result sits in an output
// register, so the next frame's detections are accepted while it waits to be
// taken. A disabled window (window_len of zero) skips the divider, write and
// sweep and answers a frame end with zeros. The history memory needs no
// clearing after reset: the fill level bounds every read to frames already
// written.
// ----------------------------------------------------------------------------
module windowed_trend_alert_filter #(
  parameter int WINDOW_MAX    = 32,
  parameter int AREA_SUM_BITS = 24
) (
  input  logic       clk,
  input  logic       rst,
  wtaf_in_if.sink    det,
  wtaf_out_if.source result,
  wtaf_cfg_if.sink   cfg
);

  localparam int SW   = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
  localparam int FW   = $clog2(WINDOW_MAX + 1);
  localparam int CENW = wtaf_pkg::CENT_W;
  localparam int WSW  = wtaf_pkg::WSUM_W;
  localparam int MW   = AREA_SUM_BITS + CENW + 1;
  localparam int PRW  = AREA_SUM_BITS + wtaf_pkg::RATIO_W;
  localparam int SUMW = ((AREA_SUM_BITS > wtaf_pkg::AREA_IN_W) ?
                         AREA_SUM_BITS : wtaf_pkg::AREA_IN_W) + 1;
  localparam logic [SUMW-1:0] AREA_MAX = (SUMW'(1) << AREA_SUM_BITS) - SUMW'(1);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_ACC   = 8'b0000_0010,
    S_LOAD  = 8'b0000_0100,
    S_DIV   = 8'b0000_1000,
    S_WRITE = 8'b0001_0000,
    S_SWEEP = 8'b0010_0000,
    S_CMP   = 8'b0100_0000,
    S_FIN   = 8'b1000_0000
  } state_t;

  state_t state;

  // Configuration registers.
  logic [wtaf_pkg::CNT_W-1:0]   window_len;
  logic [wtaf_pkg::CNT_W-1:0]   min_hit_frames;
  logic [wtaf_pkg::RATIO_W-1:0] growth_ratio;
  logic [CENW-1:0]              down_offset;

  // Captured input transfer.
  logic                          in_has;
  logic                          in_last;
  logic [wtaf_pkg::AREA_IN_W-1:0] in_area;
  logic [wtaf_pkg::PROD_W-1:0]   in_prod;

  // Frame accumulators and history bookkeeping.
  logic [AREA_SUM_BITS-1:0] frame_area;
  logic [WSW-1:0]           frame_wsum;
  logic                     frame_hit;
  logic [SW-1:0]            write_slot;
  logic [FW-1:0]            fill_level;
  logic                     full;

  // Frame-end working registers.
  logic [CENW-1:0]          cent_new;
  logic [AREA_SUM_BITS-1:0] area_new;
  logic [SW-1:0]            rd_ptr;
  logic [FW-1:0]            issued;
  logic [FW-1:0]            received;
  logic                     rd_pend;
  logic [MW-1:0]            rd_data;
  logic [AREA_SUM_BITS-1:0] old_area;
  logic [CENW-1:0]          old_cent;
  logic [FW-1:0]            sweep_hits;
  logic [PRW-1:0]           prod_reg;
  logic                     falling_reg;

  // History memory: {area, centroid, hit} per frame.
  logic [MW-1:0] hist_mem [WINDOW_MAX];

  // Divider handshake.
  logic            div_start;
  logic            div_done;
  logic [CENW-1:0] div_quot;

  // Combinational helpers.
  logic [FW-1:0]            win_eff;
  logic [SUMW-1:0]          area_sum_wide;
  logic [AREA_SUM_BITS-1:0] area_acc;
  logic [WSW:0]             wsum_wide;
  logic [WSW-1:0]           wsum_acc;
  logic [SW-1:0]            slot_inc;
  logic [SW-1:0]            rd_ptr_inc;
  logic [FW-1:0]            fill_next;
  logic [SW:0]              oldest_wide;
  logic [SW-1:0]            oldest;
  logic [FW-1:0]            received_inc;
  logic                     rising;
  logic                     out_free;

  assign det.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign div_start = (state == S_LOAD);
  assign out_free  = !result.valid || result.ready;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      window_len     <= wtaf_pkg::WINDOW_LEN_RST;
      min_hit_frames <= wtaf_pkg::MIN_HIT_RST;
      growth_ratio   <= wtaf_pkg::GROWTH_RST;
      down_offset    <= wtaf_pkg::DOWN_RST;
    end else if (cfg.valid && cfg.ready) begin
      unique case (wtaf_pkg::cfg_idx_t'(cfg.index))
        wtaf_pkg::CFG_WINDOW_LEN: window_len     <= cfg.data[wtaf_pkg::CNT_W-1:0];
        wtaf_pkg::CFG_MIN_HIT:    min_hit_frames <= cfg.data[wtaf_pkg::CNT_W-1:0];
        wtaf_pkg::CFG_GROWTH:     growth_ratio   <= cfg.data;
        wtaf_pkg::CFG_DOWN:       down_offset    <= cfg.data;
      endcase
    end
  end

  // Effective window, limited to the memory depth.
  assign win_eff = (32'(window_len) > WINDOW_MAX) ? FW'(WINDOW_MAX) : FW'(window_len);

  // Saturating frame accumulation.
  always_comb begin
    area_sum_wide = SUMW'(frame_area) + SUMW'(in_area);
    area_acc      = (area_sum_wide > AREA_MAX) ? AREA_SUM_BITS'(AREA_MAX) :
                                                 AREA_SUM_BITS'(area_sum_wide);
    wsum_wide     = {1'b0, frame_wsum} + (WSW + 1)'(in_prod);
    wsum_acc      = wsum_wide[WSW] ? '1 : wsum_wide[WSW-1:0];
  end

  // Slot arithmetic for the frame push and the oldest entry of the window.
  always_comb begin
    slot_inc     = (write_slot == SW'(WINDOW_MAX - 1)) ? '0 : write_slot + 1'b1;
    rd_ptr_inc   = (rd_ptr == SW'(WINDOW_MAX - 1)) ? '0 : rd_ptr + 1'b1;
    fill_next    = (32'(fill_level) + 1 > 32'(win_eff)) ? win_eff :
                                                          FW'(32'(fill_level) + 1);
    oldest_wide  = (SW + 1)'(slot_inc) + (SW + 1)'(WINDOW_MAX) - (SW + 1)'(fill_next);
    oldest       = (oldest_wide >= (SW + 1)'(WINDOW_MAX)) ?
                   SW'(oldest_wide - (SW + 1)'(WINDOW_MAX)) : SW'(oldest_wide);
    received_inc = received + 1'b1;
  end

  // Area growth: newest * 256 against oldest * ratio.
  assign rising = (PRW'(area_new) << 8) > prod_reg;

  // History memory, synchronous read. The write of a frame lands in the cycle
  // before its sweep starts, so reads and writes never meet on one entry.
  always_ff @(posedge clk) begin
    if (state == S_WRITE) begin
      hist_mem[write_slot] <= {frame_area, cent_new, frame_hit};
    end
    rd_data <= hist_mem[rd_ptr];
  end

  wtaf_div #(
    .AREA_SUM_BITS(AREA_SUM_BITS)
  ) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (frame_wsum),
    .divisor  (frame_area),
    .done     (div_done),
    .quotient (div_quot)
  );

  // Sequencer and control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      frame_area   <= '0;
      frame_wsum   <= '0;
      frame_hit    <= 1'b0;
      write_slot   <= '0;
      fill_level   <= '0;
      full         <= 1'b0;
      sweep_hits   <= '0;
      issued       <= '0;
      received     <= '0;
      rd_pend      <= 1'b0;
      result.valid <= 1'b0;
    end else begin
      // The output register loads a new result or empties on a transfer.
      if (state == S_FIN && out_free) begin
        result.valid <= 1'b1;
      end else if (result.valid && result.ready) begin
        result.valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (det.valid) begin
            state <= S_ACC;
          end
        end
        S_ACC: begin
          if (in_last && win_eff == '0) begin
            // Disabled window: drop the frame, report zeros.
            frame_area <= '0;
            frame_wsum <= '0;
            frame_hit  <= 1'b0;
            sweep_hits <= '0;
            full       <= 1'b0;
            state      <= S_FIN;
          end else begin
            if (in_has) begin
              frame_area <= area_acc;
              frame_wsum <= wsum_acc;
              frame_hit  <= 1'b1;
            end
            if (in_last) begin
              state <= S_LOAD;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_LOAD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          // Push the frame and set up the sweep from the oldest entry.
          write_slot <= slot_inc;
          fill_level <= fill_next;
          full       <= (fill_next == win_eff);
          frame_area <= '0;
          frame_wsum <= '0;
          frame_hit  <= 1'b0;
          sweep_hits <= '0;
          issued     <= '0;
          received   <= '0;
          rd_pend    <= 1'b0;
          state      <= S_SWEEP;
        end
        S_SWEEP: begin
          rd_pend <= (issued != fill_level);
          if (issued != fill_level) begin
            issued <= issued + 1'b1;
          end
          if (rd_pend) begin
            sweep_hits <= sweep_hits + FW'(rd_data[0]);
            received   <= received_inc;
            if (received_inc == fill_level) begin
              state <= S_CMP;
            end
          end
        end
        S_CMP: begin
          state <= S_FIN;
        end
        S_FIN: begin
          if (out_free) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Datapath registers without reset.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && det.valid) begin
      in_has  <= det.has_detection;
      in_last <= det.frame_last;
      in_area <= det.det_area;
      in_prod <= wtaf_pkg::PROD_W'(det.det_area) * wtaf_pkg::PROD_W'(det.det_centroid_y);
    end
    if (state == S_DIV && div_done) begin
      cent_new <= div_quot;
    end
    if (state == S_WRITE) begin
      area_new <= frame_area;
      rd_ptr   <= oldest;
    end
    if (state == S_SWEEP && issued != fill_level) begin
      rd_ptr <= rd_ptr_inc;
    end
    // The first entry returned by the sweep is the oldest frame.
    if (state == S_SWEEP && rd_pend && received == '0) begin
      old_area <= rd_data[MW-1:CENW+1];
      old_cent <= rd_data[CENW:1];
    end
    if (state == S_CMP) begin
      prod_reg    <= PRW'(old_area) * PRW'(growth_ratio);
      falling_reg <= (CENW + 1)'(cent_new) >
                     (CENW + 1)'(old_cent) + (CENW + 1)'(down_offset);
    end
    if (state == S_FIN && out_free) begin
      result.hit_tally        <= wtaf_pkg::CNT_W'(sweep_hits);
      result.area_rising      <= full && rising;
      result.centroid_falling <= full && falling_reg;
      result.alert            <= full && (32'(sweep_hits) >= 32'(min_hit_frames)) &&
                                 (rising || falling_reg);
    end
  end

endmodule

/* src/wtaf_checker.sv */
// ----------------------------------------------------------------------------
// wtaf_checker
// Port-level checks of the trend filter, bound to the top level.
// ----------------------------------------------------------------------------
module wtaf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       det_valid,
  input logic                       det_ready,
  input logic                       det_last,
  input logic                       res_valid,
  input logic                       res_ready,
  input logic                       res_alert,
  input logic [wtaf_pkg::CNT_W-1:0] res_hits,
  input logic                       res_rising,
  input logic                       res_falling
);

  // Frames whose last detection was transferred but whose result was not.
  logic [1:0] owed;

  always_ff @(posedge clk) begin
    if (rst) begin
      owed <= '0;
    end else begin
      owed <= owed + 2'((det_valid && det_ready && det_last) ? 1 : 0)
                   - 2'((res_valid && res_ready) ? 1 : 0);
    end
  end

  // A stalled result holds its value.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid &&
      $stable({res_alert, res_hits, res_rising, res_falling}))
    else $error("result changed while stalled");

  // An alert always comes with a trend flag.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_alert |-> res_rising || res_falling)
    else $error("alert without a trend flag");

  // A result is only offered for a frame that has ended.
  assert property (@(posedge clk) disable iff (rst)
    res_valid |-> owed != 2'd0)
    else $error("result without a finished frame");

  // With one result waiting and one frame in progress, no input is taken.
  assert property (@(posedge clk) disable iff (rst)
    owed == 2'd2 |-> !det_ready)
    else $error("input accepted with two frames outstanding");

  // Reset empties the output register.
  assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

endmodule

bind windowed_trend_alert_filter wtaf_checker u_wtaf_checker (
  .clk         (clk),
  .rst         (rst),
  .det_valid   (det.valid),
  .det_ready   (det.ready),
  .det_last    (det.frame_last),
  .res_valid   (result.valid),
  .res_ready   (result.ready),
  .res_alert   (result.alert),
  .res_hits    (result.hit_tally),
  .res_rising  (result.area_rising),
  .res_falling (result.centroid_falling)
);

/* dv/windowed_trend_alert_filter_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// windowed_trend_alert_filter_test
// Self-checking regression of the trend alert filter. Detection frames are
// driven over the input channel with random gaps and the result channel is
// stalled at random. A scoreboard predicts each frame result from its own
// copy of the history and the registers. The run starts with directed
// frames, then walks through several register settings with random frames.
// ----------------------------------------------------------------------------
module windowed_trend_alert_filter_test;

  localparam int          HIST_DEPTH    = 32;
  localparam int          AREA_ACC_W    = 24;
  localparam int unsigned RANDOM_ITEMS  = 1100;
  localparam int unsigned SETTLE_CYCLES = 80;
  localparam int unsigned CYCLE_LIMIT   = 600000;

  // One frame result as seen on the result channel.
  typedef struct packed {
    logic                       alert;
    logic [wtaf_pkg::CNT_W-1:0] hit_tally;
    logic                       area_rising;
    logic                       centroid_falling;
  } trend_t;

  // Predicts frame results and checks them in order of arrival.
  class scoreboard_t;
    logic [wtaf_pkg::CNT_W-1:0]   window_len;
    logic [wtaf_pkg::CNT_W-1:0]   alert_hits;
    logic [wtaf_pkg::RATIO_W-1:0] growth;
    logic [wtaf_pkg::CENT_W-1:0]  down_thresh;
    logic [AREA_ACC_W-1:0]        area_hist [HIST_DEPTH];
    logic [wtaf_pkg::CENT_W-1:0]  cent_hist [HIST_DEPTH];
    logic                         hit_hist  [HIST_DEPTH];
    int unsigned                  slot;
    int unsigned                  fill;
    logic [AREA_ACC_W-1:0]        area_acc;
    logic [wtaf_pkg::WSUM_W-1:0]  wsum_acc;
    logic                         seen;
    trend_t                       pending_q [$];
    int unsigned                  errors;
    int unsigned                  frames;
    int unsigned                  alerts;
    int unsigned                  rises;
    int unsigned                  falls;
    int unsigned                  disabled;
    int unsigned                  clamps;

    function new();
      window_len  = wtaf_pkg::WINDOW_LEN_RST;
      alert_hits  = wtaf_pkg::MIN_HIT_RST;
      growth      = wtaf_pkg::GROWTH_RST;
      down_thresh = wtaf_pkg::DOWN_RST;
      foreach (area_hist[i]) begin
        area_hist[i] = '0;
        cent_hist[i] = '0;
        hit_hist[i]  = 1'b0;
      end
      slot     = 0;
      fill     = 0;
      area_acc = '0;
      wsum_acc = '0;
      seen     = 1'b0;
      errors   = 0;
      frames   = 0;
      alerts   = 0;
      rises    = 0;
      falls    = 0;
      disabled = 0;
      clamps   = 0;
    endfunction

    function void write_reg(wtaf_pkg::cfg_idx_t idx,
                            logic [wtaf_pkg::CFG_DATA_W-1:0] value);
      unique case (idx)
        wtaf_pkg::CFG_WINDOW_LEN: window_len  = value[wtaf_pkg::CNT_W-1:0];
        wtaf_pkg::CFG_MIN_HIT:    alert_hits  = value[wtaf_pkg::CNT_W-1:0];
        wtaf_pkg::CFG_GROWTH:     growth      = value[wtaf_pkg::RATIO_W-1:0];
        wtaf_pkg::CFG_DOWN:       down_thresh = value[wtaf_pkg::CENT_W-1:0];
      endcase
    endfunction

    // Accumulates one accepted input; a frame end yields one expectation.
    function void note_input(logic has, logic [wtaf_pkg::AREA_IN_W-1:0] area,
                             logic [wtaf_pkg::CENT_W-1:0] cy, logic last);
      logic [AREA_ACC_W:0]         area_next;
      logic [wtaf_pkg::WSUM_W:0]   wsum_next;
      logic [wtaf_pkg::WSUM_W-1:0] quotient;
      logic [wtaf_pkg::CENT_W-1:0] mean_y;
      logic [63:0]                 grown;
      logic [63:0]                 base;
      logic [wtaf_pkg::CENT_W:0]   low_bar;
      int unsigned                 win;
      int unsigned                 newest;
      int unsigned                 oldest;
      int unsigned                 hits;
      int unsigned                 k;
      trend_t                      res;

      if (has) begin
        area_next = (AREA_ACC_W + 1)'(area_acc) + (AREA_ACC_W + 1)'(area);
        area_acc  = area_next[AREA_ACC_W] ? '1 : area_next[AREA_ACC_W-1:0];
        wsum_next = (wtaf_pkg::WSUM_W + 1)'(wsum_acc) +
                    (wtaf_pkg::WSUM_W + 1)'(area) * (wtaf_pkg::WSUM_W + 1)'(cy);
        wsum_acc  = wsum_next[wtaf_pkg::WSUM_W] ? '1 : wsum_next[wtaf_pkg::WSUM_W-1:0];
        seen      = 1'b1;
      end
      if (!last) return;

      res = '0;
      frames++;
      win = (32'(window_len) > HIST_DEPTH) ? HIST_DEPTH : 32'(window_len);

      // A zero window drops the frame and reports nothing set.
      if (win == 0) begin
        disabled++;
        area_acc = '0;
        wsum_acc = '0;
        seen     = 1'b0;
        pending_q.insert(pending_q.size(), res);
        return;
      end

      // Mean row of the frame, clamped when the quotient overflows the row range.
      mean_y = '0;
      if (area_acc != 0) begin
        quotient = wsum_acc / wtaf_pkg::WSUM_W'(area_acc);
        if (quotient > 40'hFFFF) begin
          mean_y = '1;
          clamps++;
        end else begin
          mean_y = quotient[wtaf_pkg::CENT_W-1:0];
        end
      end

      // Push the frame into the history ring.
      area_hist[slot] = area_acc;
      cent_hist[slot] = mean_y;
      hit_hist[slot]  = seen;
      newest = slot;
      slot   = (slot + 1) % HIST_DEPTH;
      fill++;
      if (fill > win) fill = win;
      area_acc = '0;
      wsum_acc = '0;
      seen     = 1'b0;

      oldest = (slot + HIST_DEPTH - fill) % HIST_DEPTH;
      hits = 0;
      for (k = 0; k < fill; k++) hits += 32'(hit_hist[(oldest + k) % HIST_DEPTH]);
      res.hit_tally = hits[wtaf_pkg::CNT_W-1:0];

      // Trend flags only once the window is full.
      if (fill >= win) begin
        grown   = {40'd0, area_hist[newest]} << 8;
        base    = 64'(area_hist[oldest]) * 64'(growth);
        low_bar = (wtaf_pkg::CENT_W + 1)'(cent_hist[oldest]) +
                  (wtaf_pkg::CENT_W + 1)'(down_thresh);
        res.area_rising      = grown > base;
        res.centroid_falling = {1'b0, cent_hist[newest]} > low_bar;
        res.alert = (hits >= 32'(alert_hits)) &&
                    (res.area_rising || res.centroid_falling);
      end
      alerts += 32'(res.alert);
      rises  += 32'(res.area_rising);
      falls  += 32'(res.centroid_falling);
      pending_q.insert(pending_q.size(), res);
    endfunction

    function void check_result(trend_t got);
      trend_t want;
      if (pending_q.size() == 0) begin
        errors++;
        $error("unexpected result: alert=%0d hit_tally=%0d rising=%0d falling=%0d",
               got.alert, got.hit_tally, got.area_rising, got.centroid_falling);
        return;
      end
      want = pending_q[0];
      pending_q.delete(0);
      if (got.alert !== want.alert) begin
        errors++;
        $error("alert: expected %0d, actual %0d", want.alert, got.alert);
      end
      if (got.hit_tally !== want.hit_tally) begin
        errors++;
        $error("hit_tally: expected %0d, actual %0d", want.hit_tally, got.hit_tally);
      end
      if (got.area_rising !== want.area_rising) begin
        errors++;
        $error("area_rising: expected %0d, actual %0d", want.area_rising, got.area_rising);
      end
      if (got.centroid_falling !== want.centroid_falling) begin
        errors++;
        $error("centroid_falling: expected %0d, actual %0d",
               want.centroid_falling, got.centroid_falling);
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  bit          calm;
  int unsigned items_sent;
  int unsigned cfg_writes;
  int unsigned cycles;
  scoreboard_t board;

  wtaf_in_if  det_ch ();
  wtaf_out_if res_ch ();
  wtaf_cfg_if cfg_ch ();

  windowed_trend_alert_filter u_dut (
    .clk    (clk),
    .rst    (rst),
    .det    (det_ch),
    .result (res_ch),
    .cfg    (cfg_ch)
  );

  always #5 clk = ~clk;

  // Result side: check every transfer, then pick the next ready.
  always @(posedge clk) begin
    if (rst) begin
      res_ch.ready <= 1'b0;
    end else begin
      if (res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
        board.check_result(trend_t'{alert: res_ch.alert, hit_tally: res_ch.hit_tally,
                                    area_rising: res_ch.area_rising,
                                    centroid_falling: res_ch.centroid_falling});
      end
      res_ch.ready <= calm || ($urandom_range(99) >= 9);
    end
  end

  // Drives one input transfer, with an occasional gap ahead of it.
  task automatic send_item(input logic has, input logic [wtaf_pkg::AREA_IN_W-1:0] area,
                           input logic [wtaf_pkg::CENT_W-1:0] cy, input logic last);
    while (!calm && $urandom_range(99) < 9) begin
      det_ch.valid <= 1'b0;
      @(posedge clk);
    end
    det_ch.valid          <= 1'b1;
    det_ch.has_detection  <= has;
    det_ch.det_area       <= area;
    det_ch.det_centroid_y <= cy;
    det_ch.frame_last     <= last;
    @(posedge clk);
    while (det_ch.ready !== 1'b1) @(posedge clk);
    board.note_input(has, area, cy, last);
    items_sent++;
  endtask

  function automatic logic [wtaf_pkg::AREA_IN_W-1:0] pick_area();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 10) return '1;
    if (sel < 50) return wtaf_pkg::AREA_IN_W'($urandom_range(4095));
    return wtaf_pkg::AREA_IN_W'($urandom);
  endfunction

  function automatic logic [wtaf_pkg::CENT_W-1:0] pick_row();
    int unsigned sel;
    sel = $urandom_range(99);
    if (sel < 5) return '0;
    if (sel < 10) return '1;
    if (sel < 50) return wtaf_pkg::CENT_W'($urandom_range(2047));
    return wtaf_pkg::CENT_W'($urandom);
  endfunction

  // One random frame: empty, ordinary, or heavy enough to saturate the sums.
  task automatic send_frame();
    int unsigned kind;
    int unsigned n_det;
    int unsigned k;
    bit          tail_marker;
    kind = $urandom_range(99);
    if (kind < 15) begin
      send_item(1'b0, pick_area(), pick_row(), 1'b1);
    end else if (kind < 18) begin
      n_det = $urandom_range(20, 17);
      for (k = 0; k < n_det; k++)
        send_item(1'b1, 20'hFFFFF - 20'($urandom_range(3)),
                  16'hFFFF - 16'($urandom_range(3)), k == n_det - 1);
    end else begin
      n_det = $urandom_range(4, 1);
      tail_marker = ($urandom_range(9) == 0);
      for (k = 0; k < n_det; k++) begin
        if ($urandom_range(9) == 0) send_item(1'b0, pick_area(), pick_row(), 1'b0);
        send_item(1'b1, pick_area(), pick_row(), (k == n_det - 1) && !tail_marker);
      end
      if (tail_marker) send_item(1'b0, pick_area(), pick_row(), 1'b1);
    end
  endtask

  task automatic write_reg(input wtaf_pkg::cfg_idx_t idx,
                           input logic [wtaf_pkg::CFG_DATA_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (cfg_ch.ready !== 1'b1) @(posedge clk);
    board.write_reg(idx, value);
    cfg_writes++;
  endtask

  // Waits until every frame result is in and the block has gone quiet.
  task automatic drain();
    det_ch.valid <= 1'b0;
    while (board.pending_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Register settings per phase: fixed settings first, some of them extremes, then random ones.
  task automatic pick_setting(input int unsigned phase,
                              output logic [wtaf_pkg::CFG_DATA_W-1:0] win,
                              output logic [wtaf_pkg::CFG_DATA_W-1:0] mins,
                              output logic [wtaf_pkg::CFG_DATA_W-1:0] ratio,
                              output logic [wtaf_pkg::CFG_DATA_W-1:0] down);
    int unsigned sel;
    int unsigned m;
    unique case (phase)
      0: begin win = 16'd1;  mins = 16'd0;  ratio = 16'd0;    down = 16'd0;    end
      1: begin win = 16'd32; mins = 16'd32; ratio = 16'hFFFF; down = 16'hFFFF; end
      2: begin win = 16'd0;  mins = 16'd3;  ratio = 16'd307;  down = 16'd80;   end
      3: begin win = 16'd63; mins = 16'd20; ratio = 16'd256;  down = 16'd16;   end
      4: begin win = 16'd4;  mins = 16'd3;  ratio = 16'd512;  down = 16'd200;  end
      5: begin win = 16'd16; mins = 16'd8;  ratio = 16'd384;  down = 16'd40;   end
      default: begin
        sel = $urandom_range(99);
        if (sel < 8) win = '0;
        else if (sel < 50) win = 16'($urandom_range(8, 1));
        else if (sel < 90) win = 16'($urandom_range(32, 9));
        else win = 16'($urandom_range(63, 33));
        m = ($urandom_range(9) == 0) ? $urandom_range(63) : $urandom_range(32'(win) + 2);
        mins = (m > 63) ? 16'd63 : 16'(m);
        // Bits above the register width should be dropped by the block.
        if ($urandom_range(1)) begin
          win[15:6]  = 10'($urandom);
          mins[15:6] = 10'($urandom);
        end
        sel = $urandom_range(99);
        if (sel < 30) ratio = 16'($urandom_range(512, 256));
        else if (sel < 60) ratio = 16'($urandom_range(1023));
        else ratio = 16'($urandom);
        sel = $urandom_range(99);
        if (sel < 20) down = '0;
        else if (sel < 60) down = 16'($urandom_range(255));
        else down = 16'($urandom);
      end
    endcase
  endtask

  initial begin : watchdog
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Run stopped after %0d cycles with %0d results outstanding.",
             cycles, board.pending_q.size());
    $display("windowed_trend_alert_filter regression: fail");
    $finish;
  end

  initial begin : stimulus
    logic [wtaf_pkg::CFG_DATA_W-1:0] win, mins, ratio, down;
    int unsigned                     phase;
    int unsigned                     target;
    int unsigned                     random_start;
    int unsigned                     k;

    board      = new();
    rst        = 1'b1;
    calm       = 1'b0;
    items_sent = 0;
    cfg_writes = 0;
    det_ch.valid          <= 1'b0;
    det_ch.has_detection  <= 1'b0;
    det_ch.det_area       <= '0;
    det_ch.det_centroid_y <= '0;
    det_ch.frame_last     <= 1'b0;
    cfg_ch.valid          <= 1'b0;
    cfg_ch.index          <= wtaf_pkg::CFG_WINDOW_LEN;
    cfg_ch.data           <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed frames under the reset settings; the eighth frame fills the window.
    send_item(1'b0, '1, '1, 1'b1);          // empty frame with junk fields
    send_item(1'b1, '0, '1, 1'b1);          // zero area still counts as a hit
    send_item(1'b1, '1, '0, 1'b0);
    send_item(1'b0, '1, '1, 1'b0);          // filler that adds nothing
    send_item(1'b1, 20'd1, 16'd1, 1'b1);
    for (k = 0; k < 17; k++)                // both sums saturate, mean row clamps
      send_item(1'b1, '1, '1, k == 16);
    send_item(1'b1, 20'd100, 16'd3200, 1'b1);
    send_item(1'b1, 20'd50, 16'd1600, 1'b1);
    send_item(1'b1, 20'd5000, 16'd4000, 1'b1);
    send_item(1'b1, 20'h80000, 16'h8000, 1'b1);

    // Random frames, one phase per register setting.
    random_start = items_sent;
    phase = 0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      drain();
      pick_setting(phase, win, mins, ratio, down);
      write_reg(wtaf_pkg::CFG_WINDOW_LEN, win);
      write_reg(wtaf_pkg::CFG_MIN_HIT, mins);
      write_reg(wtaf_pkg::CFG_GROWTH, ratio);
      write_reg(wtaf_pkg::CFG_DOWN, down);
      cfg_ch.valid <= 1'b0;
      calm = (phase == 3);
      target = items_sent + $urandom_range(130, 60);
      if (target > random_start + RANDOM_ITEMS) target = random_start + RANDOM_ITEMS;
      while (items_sent < target) send_frame();
      phase++;
    end
    drain();

    $display("Sent %0d items in %0d frames over %0d phases with %0d register writes.",
             items_sent, board.frames, phase, cfg_writes);
    $display("Saw %0d alerts, %0d rising, %0d falling, %0d disabled, %0d clamped rows.",
             board.alerts, board.rises, board.falls, board.disabled, board.clamps);
    if (board.errors == 0) begin
      $display("windowed_trend_alert_filter regression: pass");
    end else begin
      $display("windowed_trend_alert_filter regression: fail");
    end
    $finish;
  end

endmodule
